### rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;

    // Default sizes.
    localparam int unsigned DEF_TIMER_SLOTS = 16;
    localparam int unsigned DEF_ID_BITS     = 16;
    localparam int unsigned DEF_TIME_BITS   = 48;

    // Command codes of an input word.
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;
    localparam logic [1:0] CMD_ADV = 2'd2;

    // Result kinds carried on tuser.
    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_STATUS
    } stq_state_t;

endpackage

### rtl/stq_mem.sv
// Timer table storage: one write port, one registered read port.
`timescale 1ns / 1ps
module stq_mem #(
    parameter int unsigned DEPTH = stq_pkg::DEF_TIMER_SLOTS,
    parameter int unsigned WIDTH = stq_pkg::DEF_ID_BITS + stq_pkg::DEF_TIME_BITS,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sorted_timer_queue_top.sv
// Top level of the sorted timer queue: sequencer around the table memory.
`timescale 1ns / 1ps
// Sorted timer queue.
// The s_axis channel takes one command word (add, delete or advance). The
// m_axis channel returns one word per fired timer (tuser 0) and then one
// status word (tuser 1, tlast 1) with the smallest remaining delay.
// The table lives in one memory, entries kept packed from slot 0 in
// ascending order of remaining delay. Each word is handled by one pass that
// reads every live entry once, one entry per cycle unless a fired word
// stalls, and writes it back compacted, with the new timer merged in on an add.
// Timing: a word with the unused command code skips the pass and goes
// straight to its status word. The next word can be accepted in the same
// cycle as the status word appears.
// Reset empties the table at once (a live count is cleared); no clearing
// pass is needed. When the receiver stalls, the pass halts on the entry
// whose fired word is waiting and resumes when the output register frees.
module sorted_timer_queue_top #(
    parameter int unsigned TIMER_SLOTS = stq_pkg::DEF_TIMER_SLOTS,
    parameter int unsigned ID_BITS     = stq_pkg::DEF_ID_BITS,
    parameter int unsigned TIME_BITS   = stq_pkg::DEF_TIME_BITS,
    localparam int unsigned IN_W  = ((2 + ID_BITS + 2 * TIME_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((ID_BITS + TIME_BITS + 2 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // command, timer_id, delay, elapsed_time (lowest bits first)
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // fired_id, next_delay, has_pending, overflow (lowest bits first)
    output logic [OUT_W-1:0] m_axis_tdata,
    // kind
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
    localparam int unsigned EW = ID_BITS + TIME_BITS;

    // Input word fields.
    logic [1:0]           in_cmd;
    logic [ID_BITS-1:0]   in_id;
    logic [TIME_BITS-1:0] in_dly;
    logic [TIME_BITS-1:0] in_el;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_id  = s_axis_tdata[2 +: ID_BITS];
    assign in_dly = s_axis_tdata[2 + ID_BITS +: TIME_BITS];
    assign in_el  = s_axis_tdata[2 + ID_BITS + TIME_BITS +: TIME_BITS];

    stq_pkg::stq_state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        wptr_reg, wptr_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [ID_BITS-1:0]   tid_reg, tid_next;
    logic [TIME_BITS-1:0] dly_reg, dly_next;
    logic [TIME_BITS-1:0] el_reg, el_next;
    logic [ID_BITS-1:0]   h_id_reg, h_id_next;
    logic [TIME_BITS-1:0] h_rem_reg, h_rem_next;
    logic                 h_valid_reg, h_valid_next;
    logic                 h_new_reg, h_new_next;
    logic                 found_reg, found_next;
    logic [TIME_BITS-1:0] head_reg, head_next;

    logic                 o_valid_reg, o_valid_next;
    logic                 o_kind_reg, o_kind_next;
    logic [ID_BITS-1:0]   o_id_reg, o_id_next;
    logic [TIME_BITS-1:0] o_nd_reg, o_nd_next;
    logic                 o_hp_reg, o_hp_next;
    logic                 o_ov_reg, o_ov_next;
    logic                 o_last_reg, o_last_next;

    // Memory port.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    stq_mem #(
        .DEPTH (TIMER_SLOTS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS-1:0] rd_rem;
    logic [TIME_BITS-1:0] e_rem;
    logic                 is_adv;
    logic                 is_add;
    logic                 fired;
    logic                 dropped;
    logic                 out_free;
    logic                 stall;
    logic                 last_entry;

    assign rd_id      = rd_data[ID_BITS-1:0];
    assign rd_rem     = rd_data[ID_BITS +: TIME_BITS];
    assign e_rem      = rd_rem - el_reg;
    assign is_add     = (cmd_reg == stq_pkg::CMD_ADD);
    assign is_adv     = is_add || (cmd_reg == stq_pkg::CMD_ADV);
    assign fired      = is_adv && (rd_rem <= el_reg);
    assign dropped    = (cmd_reg == stq_pkg::CMD_DEL) && !found_reg && (rd_id == tid_reg);
    assign out_free   = !o_valid_reg || m_axis_tready;
    assign stall      = fired && !out_free;
    assign last_entry = ((idx_reg + CW'(1)) == cnt_reg);

    assign s_axis_tready = (state_reg == stq_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_cmd != stq_pkg::CMD_ADD && in_cmd != stq_pkg::CMD_DEL
                        && in_cmd != stq_pkg::CMD_ADV) begin
                        state_next = stq_pkg::ST_STATUS;
                    end else if (cnt_reg == '0) begin
                        state_next = stq_pkg::ST_PLACE;
                    end else begin
                        state_next = stq_pkg::ST_SCAN;
                    end
                end
            end
            stq_pkg::ST_SCAN: begin
                if (!stall && last_entry) begin
                    state_next = stq_pkg::ST_PLACE;
                end
            end
            stq_pkg::ST_PLACE: begin
                state_next = stq_pkg::ST_STATUS;
            end
            stq_pkg::ST_STATUS: begin
                if (out_free) begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        wptr_next    = wptr_reg;
        cmd_next     = cmd_reg;
        tid_next     = tid_reg;
        dly_next     = dly_reg;
        el_next      = el_reg;
        h_id_next    = h_id_reg;
        h_rem_next   = h_rem_reg;
        h_valid_next = h_valid_reg;
        h_new_next   = h_new_reg;
        found_next   = found_reg;
        head_next    = head_reg;
        o_valid_next = o_valid_reg && !m_axis_tready;
        o_kind_next  = o_kind_reg;
        o_id_next    = o_id_reg;
        o_nd_next    = o_nd_reg;
        o_hp_next    = o_hp_reg;
        o_ov_next    = o_ov_reg;
        o_last_next  = o_last_reg;
        wr_en        = 1'b0;
        wr_addr      = wptr_reg[AW-1:0];
        wr_data      = {rd_rem, rd_id};
        rd_addr      = idx_reg[AW-1:0];

        case (state_reg)
            stq_pkg::ST_IDLE: begin
                rd_addr = '0;
                if (s_axis_tvalid) begin
                    cmd_next   = in_cmd;
                    tid_next   = in_id;
                    dly_next   = in_dly;
                    el_next    = (in_cmd == stq_pkg::CMD_ADD || in_cmd == stq_pkg::CMD_ADV)
                                 ? in_el : '0;
                    idx_next   = '0;
                    wptr_next  = '0;
                    found_next = 1'b0;
                    // The new timer waits in the hold register while there is room.
                    h_id_next    = in_id;
                    h_rem_next   = in_dly;
                    h_valid_next = (in_cmd == stq_pkg::CMD_ADD)
                                   && (cnt_reg != CW'(TIMER_SLOTS));
                    h_new_next   = 1'b1;
                end
            end
            stq_pkg::ST_SCAN: begin
                if (stall) begin
                    rd_addr = idx_reg[AW-1:0];
                end else begin
                    rd_addr  = AW'(idx_reg + CW'(1));
                    idx_next = idx_reg + CW'(1);
                    if (fired) begin
                        // Expired entry: emit its id and free a slot for an add.
                        o_valid_next = 1'b1;
                        o_kind_next  = stq_pkg::KIND_FIRED;
                        o_id_next    = rd_id;
                        o_nd_next    = '0;
                        o_hp_next    = 1'b0;
                        o_ov_next    = 1'b0;
                        o_last_next  = 1'b0;
                        if (is_add) begin
                            h_valid_next = 1'b1;
                        end
                    end else if (dropped) begin
                        found_next = 1'b1;
                    end else begin
                        // Survivor: merge with the held entry, write one per cycle.
                        wr_en     = 1'b1;
                        wptr_next = wptr_reg + CW'(1);
                        if (!h_valid_reg || (h_new_reg && e_rem <= dly_reg)) begin
                            wr_data = {e_rem, rd_id};
                            if (wptr_reg == '0) begin
                                head_next = e_rem;
                            end
                        end else begin
                            wr_data    = {h_rem_reg, h_id_reg};
                            h_id_next  = rd_id;
                            h_rem_next = e_rem;
                            h_new_next = 1'b0;
                            if (wptr_reg == '0) begin
                                head_next = h_rem_reg;
                            end
                        end
                    end
                end
            end
            stq_pkg::ST_PLACE: begin
                // Flush the held entry to the tail and settle the live count.
                if (h_valid_reg) begin
                    wr_en     = 1'b1;
                    wr_data   = {h_rem_reg, h_id_reg};
                    cnt_next  = wptr_reg + CW'(1);
                    if (wptr_reg == '0) begin
                        head_next = h_rem_reg;
                    end
                end else begin
                    cnt_next = wptr_reg;
                end
            end
            stq_pkg::ST_STATUS: begin
                if (out_free) begin
                    o_valid_next = 1'b1;
                    o_kind_next  = stq_pkg::KIND_STATUS;
                    o_id_next    = '0;
                    o_nd_next    = (cnt_reg != '0) ? head_reg : '0;
                    o_hp_next    = (cnt_reg != '0);
                    o_ov_next    = is_add && !h_valid_reg;
                    o_last_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stq_pkg::ST_IDLE;
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        wptr_reg    <= wptr_next;
        cmd_reg     <= cmd_next;
        tid_reg     <= tid_next;
        dly_reg     <= dly_next;
        el_reg      <= el_next;
        h_id_reg    <= h_id_next;
        h_rem_reg   <= h_rem_next;
        h_valid_reg <= h_valid_next;
        h_new_reg   <= h_new_next;
        found_reg   <= found_next;
        head_reg    <= head_next;
        o_kind_reg  <= o_kind_next;
        o_id_reg    <= o_id_next;
        o_nd_reg    <= o_nd_next;
        o_hp_reg    <= o_hp_next;
        o_ov_reg    <= o_ov_next;
        o_last_reg  <= o_last_next;
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = OUT_W'({o_ov_reg, o_hp_reg, o_nd_reg, o_id_reg});
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;

`ifndef SYNTHESIS
    // The live count never exceeds the table size.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(TIMER_SLOTS))
        else $error("live count above table size");

    // Compaction writes never overtake the read pointer.
    a_wptr_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stq_pkg::ST_SCAN) |-> (wptr_reg <= idx_reg))
        else $error("write pointer ahead of read pointer");

    // The final word of an item is always the status word.
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == stq_pkg::KIND_STATUS))
        else $error("last word is not a status word");
`endif

endmodule

### tb/tb_sorted_timer_queue_top.sv
// Self-checking testbench for the sorted timer queue top level.
`timescale 1ns / 1ps
module tb_sorted_timer_queue_top;

    localparam int SLOTS = 16;
    localparam int IN_W  = 120;
    localparam int OUT_W = 72;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    typedef struct packed {
        logic        kind;
        logic [15:0] fired_id;
        logic [47:0] next_delay;
        logic        has_pending;
        logic        overflow;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [47:0] dly;
        logic [47:0] el;
        logic        chk;
        logic        hp;
        logic [47:0] nd;
        logic        ov;
    } stim_row_t;

    timer_result_t pending_results[$];
    int          live_n = 0;
    logic [15:0] tab_id[SLOTS];
    logic [47:0] tab_rem[SLOTS];
    int errors = 0;
    bit stim_done = 0;
    bit rx_stall_off = 0;

    sorted_timer_queue_top DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // Update the shadow table for one command word and queue its results.
    task automatic predict_timers(input logic [1:0] cmd, input logic [15:0] id,
                                  input logic [47:0] dly, input logic [47:0] el);
        int w;
        int pos;
        logic ov;
        timer_result_t r;
        ov = 1'b0;
        if (cmd == stq_pkg::CMD_ADD || cmd == stq_pkg::CMD_ADV) begin
            w = 0;
            for (int i = 0; i < live_n; i++) begin
                if (tab_rem[i] <= el) begin
                    r = '{stq_pkg::KIND_FIRED, tab_id[i], 48'd0, 1'b0, 1'b0, 1'b0};
                    pending_results.push_back(r);
                end else begin
                    tab_id[w] = tab_id[i];
                    tab_rem[w] = tab_rem[i] - el;
                    w++;
                end
            end
            live_n = w;
            if (cmd == stq_pkg::CMD_ADD) begin
                if (live_n >= SLOTS) begin
                    ov = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < live_n && tab_rem[pos] <= dly) pos++;
                    for (int i = live_n; i > pos; i--) begin
                        tab_id[i] = tab_id[i-1];
                        tab_rem[i] = tab_rem[i-1];
                    end
                    tab_id[pos] = id;
                    tab_rem[pos] = dly;
                    live_n++;
                end
            end
        end else if (cmd == stq_pkg::CMD_DEL) begin
            for (int i = 0; i < live_n; i++) begin
                if (tab_id[i] == id) begin
                    for (int k = i; k + 1 < live_n; k++) begin
                        tab_id[k] = tab_id[k+1];
                        tab_rem[k] = tab_rem[k+1];
                    end
                    live_n--;
                    break;
                end
            end
        end
        r = '{stq_pkg::KIND_STATUS, 16'd0, (live_n > 0) ? tab_rem[0] : 48'd0,
              live_n > 0, ov, 1'b1};
        pending_results.push_back(r);
    endtask

    // Drive one command word, with a random gap before it. The word stays
    // valid after acceptance until the next falling edge changes it.
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] id,
                             input logic [47:0] dly, input logic [47:0] el);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata <= {6'd0, el, dly, id, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predict_timers(cmd, id, dly, el);
    endtask

    // Take the sender off the input channel.
    task automatic stop_sending();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver stalls at random on the result channel.
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (rx_stall_off || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
                repeat (hold) @(negedge aclk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        timer_result_t e;
        timer_result_t a;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            a = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[63:16],
                  m_axis_tdata[64], m_axis_tdata[65], m_axis_tlast};
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", a);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (a.kind != e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, a.kind); errors++;
                end
                if (a.fired_id != e.fired_id) begin
                    $error("fired_id exp %0d got %0d", e.fired_id, a.fired_id); errors++;
                end
                if (a.next_delay != e.next_delay) begin
                    $error("next_delay exp %0d got %0d", e.next_delay, a.next_delay);
                    errors++;
                end
                if (a.has_pending != e.has_pending) begin
                    $error("has_pending exp %0d got %0d", e.has_pending, a.has_pending);
                    errors++;
                end
                if (a.overflow != e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, a.overflow); errors++;
                end
                if (a.last != e.last) begin
                    $error("last exp %0d got %0d", e.last, a.last); errors++;
                end
            end
        end
    end

    // Stimulus: directed table, then random traffic.
    initial begin
        stim_row_t rows[$];
        timer_result_t tail;
        logic [1:0] cmd;
        logic [15:0] id;
        logic [47:0] dly;
        logic [47:0] el;
        int pick;
        // Directed rows; status expectations typed in where obvious.
        rows.push_back('{stq_pkg::CMD_ADV, 16'd0, 48'd0, 48'd0, 1, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_DEL, 16'hFFFF, TMAX, TMAX, 1, 0, 48'd0, 0});
        rows.push_back('{CMD_NOP, 16'hFFFF, TMAX, TMAX, 1, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADD, 16'hFFFF, TMAX, 48'd0, 1, 1, TMAX, 0});
        rows.push_back('{stq_pkg::CMD_ADD, 16'd0, 48'd0, 48'd0, 1, 1, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADV, 16'd0, 48'd0, 48'd0, 1, 1, TMAX, 0});
        rows.push_back('{stq_pkg::CMD_ADV, 16'd0, 48'd0, TMAX, 1, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADD, 16'd7, 48'd100, 48'd0, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADD, 16'd7, 48'd100, 48'd0, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADD, 16'd9, 48'd50, 48'd10, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_DEL, 16'd7, 48'd0, 48'd0, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_DEL, 16'd1234, 48'd0, 48'd0, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADV, 16'd0, 48'd0, 48'd40, 0, 0, 48'd0, 0});
        for (int i = 0; i < 17; i++)
            rows.push_back('{stq_pkg::CMD_ADD, 16'(i + 100), 48'(1000 + (i % 3) * 10),
                             48'd0, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADV, 16'd0, 48'd0, 48'd1010, 0, 0, 48'd0, 0});
        rows.push_back('{stq_pkg::CMD_ADV, 16'd0, 48'd0, TMAX, 1, 0, 48'd0, 0});

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            send_word(rows[i].cmd, rows[i].id, rows[i].dly, rows[i].el);
            if (rows[i].chk) begin
                tail = pending_results[pending_results.size() - 1];
                if (tail.has_pending != rows[i].hp || tail.next_delay != rows[i].nd ||
                    tail.overflow != rows[i].ov) begin
                    $error("directed row %0d status exp hp %0d nd %0d ov %0d", i,
                           rows[i].hp, rows[i].nd, rows[i].ov);
                    errors++;
                end
            end
        end

        // Random traffic: adds, deletes, advances and the unused command code, drawn at random.
        for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 99);
            id = (live_n > 0 && $urandom_range(0, 1)) ? tab_id[$urandom_range(0, live_n - 1)]
                                                    : 16'($urandom);
            if ($urandom_range(0, 1)) dly = 48'($urandom_range(0, 2000));
            else dly = {16'($urandom), 32'($urandom)};
            if ($urandom_range(0, 3) == 0) el = {16'($urandom), 32'($urandom)};
            else el = 48'($urandom_range(0, 600));
            if (pick < 50) cmd = stq_pkg::CMD_ADD;
            else if (pick < 70) cmd = stq_pkg::CMD_DEL;
            else if (pick < 95) cmd = stq_pkg::CMD_ADV;
            else cmd = CMD_NOP;
            send_word(cmd, id, dly, el);
            if (n == 50) begin
                // Hold the sender off until every expected word has come.
                stop_sending();
                while (pending_results.size() != 0) @(posedge aclk);
            end
        end
        stop_sending();

        stim_done = 1;
        rx_stall_off = 1;
        fork
            begin
                while (pending_results.size() != 0) @(posedge aclk);
                repeat (SLOTS + 8) @(posedge aclk);
            end
            begin
                repeat (20000) @(posedge aclk);
                $display("TB_ERROR");
                $finish;
            end
        join_any
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
